### sv/colhist_pkg.sv
// Package for the colour histogram intersection engine: widths, reset values,
// register indexes and the command/status structs shared by controller and datapath.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package colhist_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_BUCKETS_DEF = 16;
    localparam int MAX_PIXELS_DEF  = 16777216;

    // Fixed field widths.
    localparam int CH_W   = 8;
    localparam int BC_W   = 5;
    localparam int DIST_W = 17;

    // Fixed-point result: 16 fraction bits, one point zero at the top.
    localparam int              FRAC_BITS = 16;
    localparam logic [DIST_W-1:0] DIST_ONE  = 17'h10000;

    // Reset value of the bucket count register.
    localparam logic [BC_W-1:0] BUCKET_COUNT_RESET = 5'd8;

    // Configuration port geometry; paddr[2] selects the register.
    localparam int   APB_ADDR_W       = 3;
    localparam int   APB_DATA_W       = 32;
    localparam logic REG_BUCKET_COUNT = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_pixel;
        logic new_target;
        logic clr_all;
        logic clr_tgt;
        logic cnt_step;
        logic calc_row;
        logic calc_addr;
        logic rd_bin;
        logic wr_bin;
        logic walk_setup;
        logic walk_count;
        logic walk;
        logic div_start;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
        logic pix_kind;
        logic pix_last;
        logic tgt_finished;
        logic pipe_busy;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### sv/colhist_pix_if.sv
// Pixel request channel of the colour histogram engine: valid/ready and the pixel fields.
// Depends on colhist_pkg for the channel width.
`default_nettype none

interface colhist_pix_if;

    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [colhist_pkg::CH_W-1:0] blue;
    logic [colhist_pkg::CH_W-1:0] green;
    logic [colhist_pkg::CH_W-1:0] red;
    logic                         last_pixel;

    modport source (output valid, kind, blue, green, red, last_pixel, input ready);
    modport sink   (input valid, kind, blue, green, red, last_pixel, output ready);

endinterface

`default_nettype wire

### sv/colhist_res_if.sv
// Result request channel of the colour histogram engine: valid/ready and the distance.
// Depends on colhist_pkg for the distance width.
`default_nettype none

interface colhist_res_if;

    logic                           valid;
    logic                           ready;
    logic [colhist_pkg::DIST_W-1:0] distance;
    logic                           no_target;

    modport source (output valid, distance, no_target, input ready);
    modport sink   (input valid, distance, no_target, output ready);

endinterface

`default_nettype wire

### sv/colhist_ctrl.sv
// Controller of the colour histogram engine: one-hot state machine that sequences
// pixel updates, clearing passes, the bin walk and the division. Uses colhist_pkg.
`default_nettype none

module colhist_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire colhist_pkg::stat_t stat,
    output colhist_pkg::cmd_t       cmd
);

    typedef enum logic [12:0] {
        S_INIT  = 13'h0001,
        S_IDLE  = 13'h0002,
        S_ROW   = 13'h0004,
        S_CLR_T = 13'h0008,
        S_ADDR  = 13'h0010,
        S_READ  = 13'h0020,
        S_WRITE = 13'h0040,
        S_SETUP = 13'h0080,
        S_COUNT = 13'h0100,
        S_WALK  = 13'h0200,
        S_DRAIN = 13'h0400,
        S_DIV   = 13'h0800,
        S_EMIT  = 13'h1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass over both stores.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_all  = 1'b1;
                cmd.cnt_step = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = S_ROW;
                end
            end
            S_ROW:
            begin
                // A target pixel after a finished target starts a new target.
                if (!stat.pix_kind && stat.tgt_finished)
                begin
                    cmd.new_target = 1'b1;
                    state_next     = S_CLR_T;
                end
                else
                begin
                    cmd.calc_row = 1'b1;
                    state_next   = S_ADDR;
                end
            end
            S_CLR_T:
            begin
                cmd.clr_tgt  = 1'b1;
                cmd.cnt_step = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_ROW;
                end
            end
            S_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                cmd.rd_bin = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_bin = 1'b1;
                if (stat.pix_kind && stat.pix_last)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SETUP:
            begin
                cmd.walk_setup = 1'b1;
                state_next     = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.walk_count = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk     = 1'b1;
                cmd.cnt_step = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/colhist_dpath.sv
// Datapath of the colour histogram engine: quantizer, bin stores, totals, the
// pipelined intersection walk, the restoring divider and the result register.
// Uses colhist_pkg; driven by colhist_ctrl through cmd_t and stat_t.
`default_nettype none

module colhist_dpath #(
    parameter int MAX_BUCKETS = colhist_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_PIXELS  = colhist_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire colhist_pkg::cmd_t              cmd,
    output colhist_pkg::stat_t                  stat,
    input  wire logic [colhist_pkg::BC_W-1:0]   bucket_count,
    input  wire logic                           kind,
    input  wire logic [colhist_pkg::CH_W-1:0]   blue,
    input  wire logic [colhist_pkg::CH_W-1:0]   green,
    input  wire logic [colhist_pkg::CH_W-1:0]   red,
    input  wire logic                           last_pixel,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [colhist_pkg::DIST_W-1:0]      distance,
    output logic                                no_target
);

    localparam int CH_W      = colhist_pkg::CH_W;
    localparam int DIST_W    = colhist_pkg::DIST_W;
    localparam int NBW       = $clog2(MAX_BUCKETS + 1);
    localparam int QW        = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int RW        = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS * MAX_BUCKETS) : 1;
    localparam int BIN_DEPTH = MAX_BUCKETS * MAX_BUCKETS * MAX_BUCKETS;
    localparam int IW        = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int CW        = $clog2(MAX_PIXELS + 1);
    localparam int PW        = 2 * CW;
    localparam int SW        = PW + 1;
    localparam int DCW       = $clog2(colhist_pkg::FRAC_BITS);
    localparam int QFW       = CH_W + NBW;
    localparam int RFW       = QW + NBW;
    localparam int AFW       = RW + NBW;

    localparam logic [CW-1:0]  CNT_MAX  = CW'(MAX_PIXELS);
    localparam logic [IW-1:0]  IDX_LAST = IW'(BIN_DEPTH - 1);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(colhist_pkg::FRAC_BITS - 1);

    // Effective bucket count: zero acts as one, large values are capped.
    logic [NBW-1:0] nb;
    always_comb
    begin
        if (bucket_count == '0)
        begin
            nb = NBW'(1);
        end
        else if (32'(bucket_count) > MAX_BUCKETS)
        begin
            nb = NBW'(MAX_BUCKETS);
        end
        else
        begin
            nb = NBW'(bucket_count);
        end
    end

    // Quantize the incoming channels: q = value * nb / 256.
    logic [QFW-1:0] qb_full;
    logic [QFW-1:0] qg_full;
    logic [QFW-1:0] qr_full;
    assign qb_full = QFW'(blue) * QFW'(nb);
    assign qg_full = QFW'(green) * QFW'(nb);
    assign qr_full = QFW'(red) * QFW'(nb);

    logic          kind_reg;
    logic          last_reg;
    logic [QW-1:0] qb_reg;
    logic [QW-1:0] qg_reg;
    logic [QW-1:0] qr_reg;
    logic [RW-1:0] row_reg;
    logic [IW-1:0] addr_reg;

    logic [RFW-1:0] row_full;
    logic [AFW-1:0] addr_full;
    assign row_full  = RFW'(qb_reg) * RFW'(nb) + RFW'(qg_reg);
    assign addr_full = AFW'(row_reg) * AFW'(nb) + AFW'(qr_reg);

    // Pixel capture and bin index; the index takes one multiply per step.
    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            kind_reg <= kind;
            last_reg <= last_pixel;
            qb_reg   <= QW'(qb_full >> CH_W);
            qg_reg   <= QW'(qg_full >> CH_W);
            qr_reg   <= QW'(qr_full >> CH_W);
        end
        if (cmd.calc_row)
        begin
            row_reg <= RW'(row_full);
        end
        if (cmd.calc_addr)
        begin
            addr_reg <= IW'(addr_full);
        end
    end

    // Sweep counter for clearing passes and the walk.
    logic [IW-1:0] cnt_reg;
    logic          cnt_last;
    assign cnt_last = (cnt_reg == IDX_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_step)
        begin
            cnt_reg <= cnt_last ? '0 : cnt_reg + IW'(1);
        end
    end

    // Bin stores: pixel updates use the bin index, sweeps use the counter.
    logic [CW-1:0] tgt_mem [BIN_DEPTH];
    logic [CW-1:0] img_mem [BIN_DEPTH];
    logic [CW-1:0] t_rd_reg;
    logic [CW-1:0] i_rd_reg;
    logic [IW-1:0] mem_addr;
    logic [CW-1:0] t_inc;
    logic [CW-1:0] i_inc;

    assign mem_addr = (cmd.rd_bin || cmd.wr_bin) ? addr_reg : cnt_reg;
    assign t_inc    = (t_rd_reg < CNT_MAX) ? t_rd_reg + CW'(1) : t_rd_reg;
    assign i_inc    = (i_rd_reg < CNT_MAX) ? i_rd_reg + CW'(1) : i_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_bin || cmd.walk)
        begin
            t_rd_reg <= tgt_mem[mem_addr];
        end
        if (cmd.clr_all || cmd.clr_tgt)
        begin
            tgt_mem[mem_addr] <= '0;
        end
        else if (cmd.wr_bin && !kind_reg)
        begin
            tgt_mem[mem_addr] <= t_inc;
        end
    end

    // The walk empties the image store behind itself.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_bin || cmd.walk)
        begin
            i_rd_reg <= img_mem[mem_addr];
        end
        if (cmd.clr_all || cmd.walk)
        begin
            img_mem[mem_addr] <= '0;
        end
        else if (cmd.wr_bin && kind_reg)
        begin
            img_mem[mem_addr] <= i_inc;
        end
    end

    // Totals and the finished-target flag.
    logic [CW-1:0] tt_reg;
    logic [CW-1:0] it_reg;
    logic          fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tt_reg  <= '0;
            it_reg  <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            if (cmd.new_target)
            begin
                tt_reg  <= '0;
                fin_reg <= 1'b0;
            end
            else if (cmd.wr_bin && !kind_reg)
            begin
                if (tt_reg < CNT_MAX)
                begin
                    tt_reg <= tt_reg + CW'(1);
                end
                if (last_reg)
                begin
                    fin_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                it_reg <= '0;
            end
            else if (cmd.wr_bin && kind_reg && (it_reg < CNT_MAX))
            begin
                it_reg <= it_reg + CW'(1);
            end
        end
    end

    // Walk set-up: the normalizing product and the number of live bins.
    logic [PW-1:0]    prod_reg;
    logic [2*NBW-1:0] sq_reg;
    logic [IW:0]      n_reg;
    logic [3*NBW-1:0] n_full;
    assign n_full = (3 * NBW)'(sq_reg) * (3 * NBW)'(nb);

    always_ff @(posedge clk)
    begin
        if (cmd.walk_setup)
        begin
            prod_reg <= PW'(tt_reg) * PW'(it_reg);
            sq_reg   <= (2 * NBW)'(nb) * (2 * NBW)'(nb);
        end
        if (cmd.walk_count)
        begin
            n_reg <= (IW + 1)'(n_full);
        end
    end

    // Walk pipeline: read, cross products, clamped accumulation.
    logic          v1_reg;
    logic          in1_reg;
    logic          v2_reg;
    logic [PW-1:0] x_reg;
    logic [PW-1:0] y_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_add;
    logic [SW-1:0] prod_ext;

    assign prod_ext = SW'(prod_reg);
    assign sum_add  = sum_reg + SW'((x_reg < y_reg) ? x_reg : y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.walk;
            v2_reg <= v1_reg && in1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk)
        begin
            in1_reg <= ({1'b0, cnt_reg} < n_reg);
        end
        if (v1_reg)
        begin
            x_reg <= PW'(t_rd_reg) * PW'(it_reg);
            y_reg <= PW'(i_rd_reg) * PW'(tt_reg);
        end
        if (cmd.walk_setup)
        begin
            sum_reg <= '0;
        end
        else if (v2_reg)
        begin
            sum_reg <= (sum_add > prod_ext) ? prod_ext : sum_add;
        end
    end

    // Restoring divider: 16 fraction bits of sum / prod, one bit a cycle.
    logic [DIST_W-1:0] q_reg;
    logic [SW-1:0]     r_reg;
    logic [SW-1:0]     r_shift;
    logic              r_ge;
    logic              div_busy_reg;
    logic [DCW-1:0]    div_cnt_reg;

    assign r_shift = {r_reg[SW-2:0], 1'b0};
    assign r_ge    = (r_shift >= prod_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + DCW'(1);
            if (div_cnt_reg == DIV_LAST)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            // The sum never exceeds the product, so the integer part is 0 or 1.
            if (sum_reg >= prod_ext)
            begin
                q_reg <= DIST_W'(1);
                r_reg <= '0;
            end
            else
            begin
                q_reg <= '0;
                r_reg <= sum_reg;
            end
        end
        else if (div_busy_reg)
        begin
            q_reg <= {q_reg[DIST_W-2:0], r_ge};
            r_reg <= r_ge ? r_shift - prod_ext : r_shift;
        end
    end

    // Result register.
    logic              out_valid_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              no_target_reg;
    logic              out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (!fin_reg || (prod_reg == '0))
            begin
                distance_reg <= colhist_pkg::DIST_ONE;
            end
            else
            begin
                distance_reg <= colhist_pkg::DIST_ONE - q_reg;
            end
            no_target_reg <= !fin_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign no_target = no_target_reg;

    // Status to the controller.
    always_comb
    begin
        stat.cnt_last     = cnt_last;
        stat.pix_kind     = kind_reg;
        stat.pix_last     = last_reg;
        stat.tgt_finished = fin_reg;
        stat.pipe_busy    = v1_reg || v2_reg;
        stat.div_busy     = div_busy_reg;
        stat.out_free     = out_free;
    end

endmodule

`default_nettype wire

### sv/color_histogram_intersection.sv
// Colour histogram intersection engine. A pixel goes through the index multiply, bin
// read and bin write before the next pixel is accepted. A target pixel after a finished
// target first clears the target store. A last image pixel adds the bin walk, one bin
// a cycle, then a 16-step divider; the next pixel is taken only once the result is
// issued, and later while an earlier result still waits. After reset both stores are
// cleared before pixels are taken.
// Top level: APB register, controller and datapath; uses colhist_pkg and the
// colhist_pix_if / colhist_res_if channel interfaces.
`default_nettype none

module color_histogram_intersection #(
    parameter int MAX_BUCKETS = colhist_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_PIXELS  = colhist_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    colhist_pix_if.sink                              pixel,
    colhist_res_if.source                            result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [colhist_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [colhist_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [colhist_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                     pready
);

    localparam int BC_W = colhist_pkg::BC_W;

    // Bucket count register.
    logic [BC_W-1:0] bucket_count_reg;
    logic            reg_hit;
    assign reg_hit = (paddr[2] == colhist_pkg::REG_BUCKET_COUNT);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= colhist_pkg::BUCKET_COUNT_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            bucket_count_reg <= pwdata[BC_W-1:0];
        end
    end

    assign prdata = reg_hit ? colhist_pkg::APB_DATA_W'(bucket_count_reg) : '0;

    // Controller and datapath.
    colhist_pkg::cmd_t  cmd;
    colhist_pkg::stat_t stat;

    colhist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    colhist_dpath #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_PIXELS  (MAX_PIXELS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .bucket_count (bucket_count_reg),
        .kind         (pixel.kind),
        .blue         (pixel.blue),
        .green        (pixel.green),
        .red          (pixel.red),
        .last_pixel   (pixel.last_pixel),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .distance     (result.distance),
        .no_target    (result.no_target)
    );

endmodule

`default_nettype wire
